### rtl/gdtp_pkg.sv
// ----------------------------------------------------------------------------
// gdtp_pkg: shared types, constants and parse functions
// Character classes, parse state layout and the per-character step logic of
// the grouped decimal text parser.
// ----------------------------------------------------------------------------
`default_nettype none

package gdtp_pkg;

  // Default digit bounds
  localparam int MAX_SIGNIFICANT_DIGITS_DEF = 18;
  localparam int MAX_FRACTION_DIGITS_DEF    = 63;

  // Field widths
  localparam int CHAR_W  = 8;
  localparam int ACC_W   = 64;   // holds up to 19 digits before the 60-bit check
  localparam int MAG_W   = 60;
  localparam int SIG_W   = 5;    // significant digit count, up to bound + 1
  localparam int SCALE_W = 7;    // fraction digit count, saturates at 64
  localparam int FRAC_W  = 6;
  localparam int GRP_W   = 3;

  localparam logic [ACC_W-1:0] MAG_MAX = {{(ACC_W-MAG_W){1'b0}}, {MAG_W{1'b1}}};

  // Characters
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PCT   = 8'h25;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UC_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UC_Z  = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LC_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LC_N  = 8'h6E;
  localparam logic [CHAR_W-1:0] CASE_GAP = 8'h20;

  typedef enum logic [2:0] {
    PH_LEAD,
    PH_CORE,
    PH_SIGNED,
    PH_INT,
    PH_FRAC
  } phase_e;

  typedef enum logic [2:0] {
    TK_START,
    TK_DASH,
    TK_N,
    TK_NSL,
    TK_NA,
    TK_NSLA,
    TK_DEAD
  } token_e;

  typedef enum logic [1:0] {
    ST_AVAILABLE,
    ST_UNAVAILABLE,
    ST_MALFORMED
  } status_e;

  typedef enum logic [2:0] {
    ERR_NONE,
    ERR_NO_PERCENT,
    ERR_MISSING_DIGITS,
    ERR_TWO_POINTS,
    ERR_INCOMPLETE,
    ERR_BAD_FRACTION,
    ERR_BAD_GROUPING,
    ERR_TOO_LONG
  } err_e;

  typedef struct packed {
    logic [CHAR_W-1:0] chr;
    logic              last;
  } in_item_t;

  typedef struct packed {
    phase_e             phase;
    token_e             tok;
    logic [GRP_W-1:0]   grp_len;
    logic               comma_seen;
    logic               fl_two_points;
    logic               fl_incomplete;
    logic               fl_bad_frac;
    logic               fl_bad_group;
    logic               neg;
    logic               pend_blank;
    logic               pend_pct;
    logic [ACC_W-1:0]   acc;
    logic [SIG_W-1:0]   sig_cnt;
    logic [SCALE_W-1:0] scale;
  } parse_st_t;

  typedef struct packed {
    status_e           status;
    err_e              code;
    logic              neg;
    logic [MAG_W-1:0]  mag;
    logic [FRAC_W-1:0] frac;
  } result_t;

  localparam parse_st_t PARSE_ST_RST = '{
    phase:         PH_LEAD,
    tok:           TK_START,
    grp_len:       '0,
    comma_seen:    1'b0,
    fl_two_points: 1'b0,
    fl_incomplete: 1'b0,
    fl_bad_frac:   1'b0,
    fl_bad_group:  1'b0,
    neg:           1'b0,
    pend_blank:    1'b0,
    pend_pct:      1'b0,
    acc:           '0,
    sig_cnt:       '0,
    scale:         '0
  };

  function automatic logic is_blank(input logic [CHAR_W-1:0] c);
    return c inside {CH_SPACE, [CH_TAB:CH_CR]};
  endfunction

  function automatic logic is_digit(input logic [CHAR_W-1:0] c);
    return c inside {[CH_ZERO:CH_NINE]};
  endfunction

  function automatic token_e advance_token(input token_e t, input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] lc;
    token_e            r;
    lc = (c inside {[CH_UC_A:CH_UC_Z]}) ? c + CASE_GAP : c;
    case (t)
      TK_START: begin
        r = (lc == CH_MINUS) ? TK_DASH : (lc == CH_LC_N) ? TK_N : TK_DEAD;
      end
      TK_N: begin
        r = (lc == CH_SLASH) ? TK_NSL : (lc == CH_LC_A) ? TK_NA : TK_DEAD;
      end
      TK_NSL: begin
        r = (lc == CH_LC_A) ? TK_NSLA : TK_DEAD;
      end
      default: begin
        r = TK_DEAD;
      end
    endcase
    return r;
  endfunction

  // Leading zeros are dropped; digits past the bound only mark the overflow.
  function automatic parse_st_t take_digit(input parse_st_t s, input logic [3:0] d,
                                           input logic [SIG_W-1:0] max_sig);
    parse_st_t r;
    r = s;
    if (s.sig_cnt != '0 || d != 4'd0) begin
      if (s.sig_cnt < max_sig) begin
        r.acc     = {s.acc[ACC_W-4:0], 3'b000} + {s.acc[ACC_W-2:0], 1'b0}
                  + {{(ACC_W-4){1'b0}}, d};
        r.sig_cnt = s.sig_cnt + SIG_W'(1);
      end else begin
        r.sig_cnt = max_sig + SIG_W'(1);
      end
    end
    return r;
  endfunction

  // Feed one non-blank character into the number grammar.
  function automatic parse_st_t commit_char(input parse_st_t s, input logic [CHAR_W-1:0] c,
                                            input logic pct, input logic [SIG_W-1:0] max_sig);
    parse_st_t r;
    logic      done;
    r    = s;
    done = 1'b0;
    if (r.phase == PH_CORE) begin
      r.phase = PH_SIGNED;
      if (c == CH_PLUS || c == CH_MINUS) begin
        r.neg = (c == CH_MINUS);
        done  = 1'b1;
      end
    end
    if (!done && r.phase == PH_SIGNED) begin
      if (c == CH_POINT) begin
        r.fl_incomplete = 1'b1;
        r.phase         = PH_FRAC;
        done            = 1'b1;
      end else begin
        r.phase = PH_INT;
      end
    end
    if (!done && r.phase == PH_INT) begin
      done = 1'b1;
      if (is_digit(c)) begin
        if (r.grp_len < GRP_W'(4)) begin
          r.grp_len = r.grp_len + GRP_W'(1);
        end
        if (r.comma_seen && r.grp_len > GRP_W'(3)) begin
          r.fl_bad_group = 1'b1;
        end
        r = take_digit(r, c[3:0], max_sig);
      end else if (c == CH_COMMA) begin
        if (pct) begin
          r.fl_bad_group = 1'b1;
        end
        if (!r.comma_seen) begin
          if (r.grp_len == '0 || r.grp_len > GRP_W'(3)) begin
            r.fl_bad_group = 1'b1;
          end
        end else if (r.grp_len != GRP_W'(3)) begin
          r.fl_bad_group = 1'b1;
        end
        r.comma_seen = 1'b1;
        r.grp_len    = '0;
      end else if (c == CH_POINT) begin
        if (r.comma_seen && r.grp_len != GRP_W'(3)) begin
          r.fl_bad_group = 1'b1;
        end
        r.phase = PH_FRAC;
      end else begin
        r.fl_bad_group = 1'b1;
      end
    end
    if (!done && r.phase == PH_FRAC) begin
      if (c == CH_POINT) begin
        r.fl_two_points = 1'b1;
      end else begin
        if (r.scale < SCALE_W'(64)) begin
          r.scale = r.scale + SCALE_W'(1);
        end
        if (is_digit(c)) begin
          r = take_digit(r, c[3:0], max_sig);
        end else begin
          r.fl_bad_frac = 1'b1;
        end
      end
    end
    return r;
  endfunction

  // Close the field: settle a held '%' and pick the result by error priority.
  function automatic result_t finish_field(input parse_st_t s, input logic pct,
                                           input logic [SIG_W-1:0] max_sig,
                                           input logic [SCALE_W-1:0] frac_lim);
    parse_st_t t;
    result_t   r;
    t = s;
    if (!pct && s.pend_pct) begin
      t          = commit_char(s, CH_PCT, 1'b0, max_sig);
      t.pend_pct = 1'b0;
    end
    r = '{status: ST_MALFORMED, code: ERR_NONE, neg: 1'b0, mag: '0, frac: '0};
    if (t.phase == PH_LEAD || t.tok == TK_DASH || t.tok == TK_NA || t.tok == TK_NSLA) begin
      r.status = ST_UNAVAILABLE;
    end else if (pct && !t.pend_pct) begin
      r.code = ERR_NO_PERCENT;
    end else if (t.phase == PH_CORE || t.phase == PH_SIGNED) begin
      r.code = ERR_MISSING_DIGITS;
    end else if (t.fl_two_points) begin
      r.code = ERR_TWO_POINTS;
    end else if (t.fl_incomplete || (t.phase == PH_FRAC && t.scale == '0)) begin
      r.code = ERR_INCOMPLETE;
    end else if (t.fl_bad_frac) begin
      r.code = ERR_BAD_FRACTION;
    end else if (t.fl_bad_group ||
                 (t.phase == PH_INT && t.comma_seen && t.grp_len != GRP_W'(3))) begin
      r.code = ERR_BAD_GROUPING;
    end else if (t.sig_cnt > max_sig || t.acc > MAG_MAX || t.scale > frac_lim) begin
      r.code = ERR_TOO_LONG;
    end else begin
      r.status = ST_AVAILABLE;
      r.mag    = t.acc[MAG_W-1:0];
      r.neg    = t.neg && (t.sig_cnt != '0);
      r.frac   = t.scale[FRAC_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/gdtp_parse_core.sv
// ----------------------------------------------------------------------------
// gdtp_parse_core: parse state register and per-character step
// Advances the field state by one character per cycle while step_i is high, and
// forms the result when the last character of a field is stepped.
// ----------------------------------------------------------------------------
`default_nettype none

module gdtp_parse_core
  import gdtp_pkg::*;
#(
  parameter int MAX_SIGNIFICANT_DIGITS = MAX_SIGNIFICANT_DIGITS_DEF,
  parameter int MAX_FRACTION_DIGITS    = MAX_FRACTION_DIGITS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     step_i,
  input  in_item_t item_i,
  input  logic     pct_mode_i,
  output result_t  result_o
);

  localparam int FracLim = (MAX_FRACTION_DIGITS < 63) ? MAX_FRACTION_DIGITS : 63;
  localparam logic [SIG_W-1:0]   MaxSig   = SIG_W'(MAX_SIGNIFICANT_DIGITS);
  localparam logic [SCALE_W-1:0] FracLimit = SCALE_W'(FracLim);

  parse_st_t st_q, st_d, st_step;
  logic      pend_pct, pend_blank;

  always_comb begin
    st_step    = st_q;
    pend_pct   = st_q.pend_pct;
    pend_blank = st_q.pend_blank;
    if (is_blank(item_i.chr)) begin
      if (st_q.phase != PH_LEAD) begin
        st_step.pend_blank = 1'b1;
      end
    end else begin
      // a blank inside the text kills any unavailable token
      if (pend_blank) begin
        st_step.tok = TK_DEAD;
      end
      st_step.tok = advance_token(st_step.tok, item_i.chr);
      if (st_step.phase == PH_LEAD) begin
        st_step.phase = PH_CORE;
      end
      if (pend_pct) begin
        st_step = commit_char(st_step, CH_PCT, pct_mode_i, MaxSig);
      end
      if (pend_blank) begin
        st_step = commit_char(st_step, CH_SPACE, pct_mode_i, MaxSig);
      end
      st_step.pend_blank = 1'b0;
      st_step.pend_pct   = 1'b0;
      if (pct_mode_i && item_i.chr == CH_PCT) begin
        st_step.pend_pct = 1'b1;
      end else begin
        st_step = commit_char(st_step, item_i.chr, pct_mode_i, MaxSig);
      end
    end
    result_o = finish_field(st_step, pct_mode_i, MaxSig, FracLimit);

    st_d = st_q;
    if (step_i) begin
      st_d = item_i.last ? PARSE_ST_RST : st_step;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= PARSE_ST_RST;
    end else begin
      st_q <= st_d;
    end
  end

endmodule

`default_nettype wire

### rtl/grouped_decimal_text_parser.sv
// ----------------------------------------------------------------------------
// grouped_decimal_text_parser: streaming decimal text field parser
// Reads a text field one character per transfer and returns one parsed
// number (status, error, sign, magnitude, scale) per field.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+-----------------------------
//   in      | input     | in_valid_i / in_stall_o    | character_i, final_char_i
//   out     | output    | out_valid_o / out_stall_i  | status_o, error_code_o,
//           |           |                            | is_negative_o, magnitude_o,
//           |           |                            | fraction_digits_o
//   cfg     | input     | cfg_valid_i / cfg_ready_o  | cfg_data_i (percent_mode)
//
// One character per cycle is taken while in_stall_o is low; the parse state
// register and its single step of logic set that rate.
// A field's last character is registered in the input register; its result is then
// registered in the result register, and out_valid_o rises when that register loads.
// in_stall_o rises only while a last character waits behind a full, stalled
// result register. Reset clears control state and percent_mode; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module grouped_decimal_text_parser
  import gdtp_pkg::*;
#(
  parameter int MAX_SIGNIFICANT_DIGITS = MAX_SIGNIFICANT_DIGITS_DEF,
  parameter int MAX_FRACTION_DIGITS    = MAX_FRACTION_DIGITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // character stream
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [CHAR_W-1:0] character_i,
  input  logic              final_char_i,
  // parsed numbers
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        status_o,
  output logic [2:0]        error_code_o,
  output logic              is_negative_o,
  output logic [MAG_W-1:0]  magnitude_o,
  output logic [FRAC_W-1:0] fraction_digits_o,
  // configuration write
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic              cfg_data_i
);

  logic     pct_mode_q;
  logic     in_valid_q;
  in_item_t in_q;
  logic     out_valid_q;
  result_t  out_q;
  result_t  result;
  logic     step;
  logic     in_take;
  logic     out_load;

  // Configuration is always taken; the user must write it only while idle, as the block does not enforce this.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pct_mode_q <= 1'b0;
    end else if (cfg_valid_i) begin
      pct_mode_q <= cfg_data_i;
    end
  end

  // Advance the held character unless it closes a field and the result
  // register cannot take the new result this cycle.
  assign step       = in_valid_q && !(in_q.last && out_valid_q && out_stall_i);
  assign in_stall_o = in_valid_q && !step;
  assign in_take    = in_valid_i && !in_stall_o;
  assign out_load   = step && in_q.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= '{chr: character_i, last: final_char_i};
    end
  end

  gdtp_parse_core #(
    .MAX_SIGNIFICANT_DIGITS (MAX_SIGNIFICANT_DIGITS),
    .MAX_FRACTION_DIGITS    (MAX_FRACTION_DIGITS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .item_i     (in_q),
    .pct_mode_i (pct_mode_q),
    .result_o   (result)
  );

  // Result register: load a closing result, drop it once transferred.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= result;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = out_q.status;
  assign error_code_o      = out_q.code;
  assign is_negative_o     = out_q.neg;
  assign magnitude_o       = out_q.mag;
  assign fraction_digits_o = out_q.frac;

endmodule

`default_nettype wire

### rtl/gdtp_checker.sv
// ----------------------------------------------------------------------------
// gdtp_checker: port-level checks for the parser
// Watches the result channel of grouped_decimal_text_parser; bound below.
// ----------------------------------------------------------------------------
`default_nettype none

module gdtp_checker
  import gdtp_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire logic [1:0]        status_o,
  input wire logic [2:0]        error_code_o,
  input wire logic              is_negative_o,
  input wire logic [MAG_W-1:0]  magnitude_o,
  input wire logic [FRAC_W-1:0] fraction_digits_o
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o &&
      $stable(status_o) && $stable(error_code_o) && $stable(magnitude_o))
    else $error("stalled result changed or dropped");

  // An error code goes with malformed status and only with it.
  a_err_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((status_o == ST_MALFORMED) == (error_code_o != ERR_NONE)))
    else $error("error code does not match status");

  // Unavailable and malformed results carry no number.
  a_empty_number: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_AVAILABLE |->
      magnitude_o == '0 && fraction_digits_o == '0 && !is_negative_o)
    else $error("number fields set on a result that is not available");

  // Zero is never negative.
  a_neg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_negative_o |-> magnitude_o != '0)
    else $error("negative zero");

endmodule

bind grouped_decimal_text_parser gdtp_checker u_gdtp_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .status_o          (status_o),
  .error_code_o      (error_code_o),
  .is_negative_o     (is_negative_o),
  .magnitude_o       (magnitude_o),
  .fraction_digits_o (fraction_digits_o)
);

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for grouped_decimal_text_parser
// Streams text fields one character per transfer, predicts every parsed
// number in a cycle-free model, and compares each result field by field.
// ----------------------------------------------------------------------------

module tb;
  import gdtp_pkg::*;

  localparam int MAX_SIG  = MAX_SIGNIFICANT_DIGITS_DEF;
  localparam int MAX_FRAC = MAX_FRACTION_DIGITS_DEF;

  // Field-level parse state kept by the predictor.
  typedef struct packed {
    phase_e      ph;
    token_e      tk;
    logic [2:0]  grp;
    logic        commas;
    logic        two_pts;
    logic        incompl;
    logic        bad_frac;
    logic        bad_grp;
    logic        minus;
    logic        pend_blank;
    logic        pend_pct;
    logic [63:0] acc;
    logic [4:0]  sig;
    logic [6:0]  scale;
  } field_t;

  localparam field_t FIELD_CLEAR = '{ph: PH_LEAD, tk: TK_START, default: '0};

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [CHAR_W-1:0] character_i = '0;
  logic              final_char_i = 1'b0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [1:0]        status_o;
  logic [2:0]        error_code_o;
  logic              is_negative_o;
  logic [MAG_W-1:0]  magnitude_o;
  logic [FRAC_W-1:0] fraction_digits_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic              cfg_data_i = 1'b0;

  in_item_t text_q[$];          // characters waiting to be driven
  result_t  pending_numbers[$]; // parsed numbers predicted, not yet seen
  in_item_t next_char;
  field_t   cur = FIELD_CLEAR;  // predictor state of the field in progress
  logic     pct_mode = 1'b0;    // predictor copy of percent_mode

  logic     calm = 1'b0;        // suppress random idling on both sides
  logic     hold_results = 1'b0;
  logic     hold_done = 1'b0;
  int       hold_left = 0;

  int       chars_queued = 0;
  int       fields_queued = 0;
  int       numbers_checked = 0;
  int       mismatches = 0;

  grouped_decimal_text_parser dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .character_i      (character_i),
    .final_char_i     (final_char_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .error_code_o     (error_code_o),
    .is_negative_o    (is_negative_o),
    .magnitude_o      (magnitude_o),
    .fraction_digits_o(fraction_digits_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  function automatic logic is_space(logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic is_numeral(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  // Walk the unavailable-token matcher; letters compare case-blind.
  function automatic token_e track_token(token_e t, logic [7:0] c);
    logic [7:0] lc;
    token_e     nxt;
    lc = (c >= CH_UC_A && c <= CH_UC_Z) ? c + CASE_GAP : c;
    case (t)
      TK_START: nxt = (lc == CH_MINUS) ? TK_DASH : (lc == CH_LC_N) ? TK_N : TK_DEAD;
      TK_N:     nxt = (lc == CH_SLASH) ? TK_NSL : (lc == CH_LC_A) ? TK_NA : TK_DEAD;
      TK_NSL:   nxt = (lc == CH_LC_A) ? TK_NSLA : TK_DEAD;
      default:  nxt = TK_DEAD;
    endcase
    return nxt;
  endfunction

  // Drop leading zeros; past the digit bound only flag the overflow.
  function automatic field_t add_digit(field_t s, logic [3:0] d);
    if (s.sig == 0 && d == 0) return s;
    if (s.sig < MAX_SIG) begin
      s.acc = s.acc * 64'd10 + 64'(d);
      s.sig = s.sig + 5'd1;
    end else begin
      s.sig = 5'(MAX_SIG + 1);
    end
    return s;
  endfunction

  // Advance the number grammar by one non-blank character.
  function automatic field_t apply_char(field_t s, logic [7:0] c, logic pct);
    if (s.ph == PH_CORE) begin
      s.ph = PH_SIGNED;
      if (c == CH_PLUS || c == CH_MINUS) begin
        s.minus = (c == CH_MINUS);
        return s;
      end
    end
    if (s.ph == PH_SIGNED) begin
      if (c == CH_POINT) begin
        s.incompl = 1'b1;
        s.ph      = PH_FRAC;
        return s;
      end
      s.ph = PH_INT;
    end
    if (s.ph == PH_INT) begin
      if (is_numeral(c)) begin
        if (s.grp < 3'd4) s.grp = s.grp + 3'd1;
        if (s.commas && s.grp > 3'd3) s.bad_grp = 1'b1;
        s = add_digit(s, c[3:0]);
      end else if (c == CH_COMMA) begin
        if (pct || (!s.commas && (s.grp == 3'd0 || s.grp > 3'd3)) ||
            (s.commas && s.grp != 3'd3)) begin
          s.bad_grp = 1'b1;
        end
        s.commas = 1'b1;
        s.grp    = 3'd0;
      end else if (c == CH_POINT) begin
        if (s.commas && s.grp != 3'd3) s.bad_grp = 1'b1;
        s.ph = PH_FRAC;
      end else begin
        s.bad_grp = 1'b1;
      end
      return s;
    end
    if (s.ph == PH_FRAC) begin
      if (c == CH_POINT) begin
        s.two_pts = 1'b1;
      end else begin
        if (s.scale < 7'd64) s.scale = s.scale + 7'd1;
        if (is_numeral(c)) s = add_digit(s, c[3:0]);
        else s.bad_frac = 1'b1;
      end
    end
    return s;
  endfunction

  // Settle a held percent sign, then pick the outcome by error priority.
  function automatic result_t close_field(field_t s, logic pct);
    result_t r;
    if (!pct && s.pend_pct) begin
      s          = apply_char(s, CH_PCT, 1'b0);
      s.pend_pct = 1'b0;
    end
    r = '{status: ST_MALFORMED, code: ERR_NONE, neg: 1'b0, mag: '0, frac: '0};
    if (s.ph == PH_LEAD || s.tk == TK_DASH || s.tk == TK_NA || s.tk == TK_NSLA) begin
      r.status = ST_UNAVAILABLE;
    end else if (pct && !s.pend_pct) begin
      r.code = ERR_NO_PERCENT;
    end else if (s.ph == PH_CORE || s.ph == PH_SIGNED) begin
      r.code = ERR_MISSING_DIGITS;
    end else if (s.two_pts) begin
      r.code = ERR_TWO_POINTS;
    end else if (s.incompl || (s.ph == PH_FRAC && s.scale == 7'd0)) begin
      r.code = ERR_INCOMPLETE;
    end else if (s.bad_frac) begin
      r.code = ERR_BAD_FRACTION;
    end else if (s.bad_grp || (s.ph == PH_INT && s.commas && s.grp != 3'd3)) begin
      r.code = ERR_BAD_GROUPING;
    end else if (s.sig > MAX_SIG || s.acc > MAG_MAX || s.scale > MAX_FRAC ||
                 s.scale > 7'd63) begin
      r.code = ERR_TOO_LONG;
    end else begin
      r.status = ST_AVAILABLE;
      r.mag    = s.acc[MAG_W-1:0];
      r.neg    = s.minus && (s.sig != 0);
      r.frac   = s.scale[FRAC_W-1:0];
    end
    return r;
  endfunction

  // Fold one accepted character into the field; a last mark yields a number.
  task automatic parse_char(input logic [7:0] c, input logic last);
    if (is_space(c)) begin
      if (cur.ph != PH_LEAD) cur.pend_blank = 1'b1;
    end else begin
      // a blank inside the text kills any unavailable token
      if (cur.pend_blank) cur.tk = TK_DEAD;
      cur.tk = track_token(cur.tk, c);
      if (cur.ph == PH_LEAD) cur.ph = PH_CORE;
      // a held percent or blank turned out not to be trailing: replay it
      if (cur.pend_pct) cur = apply_char(cur, CH_PCT, pct_mode);
      if (cur.pend_blank) cur = apply_char(cur, CH_SPACE, pct_mode);
      cur.pend_blank = 1'b0;
      cur.pend_pct   = 1'b0;
      if (pct_mode && c == CH_PCT) cur.pend_pct = 1'b1;
      else cur = apply_char(cur, c, pct_mode);
    end
    if (last) begin
      pending_numbers = {pending_numbers, close_field(cur, pct_mode)};
      cur = FIELD_CLEAR;
    end
  endtask

  // --------------------------------------------------------------------------
  // Character driver: hold a stalled transfer, otherwise offer the next
  // character or idle at random.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      character_i  <= '0;
      final_char_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        parse_char(character_i, final_char_i);
      end
      if (!in_valid_i || !in_stall_o) begin
        if (text_q.size() != 0 && (calm || $urandom_range(0, 99) >= 33)) begin
          next_char    = text_q.pop_front();
          in_valid_i   <= 1'b1;
          character_i  <= next_char.chr;
          final_char_i <= next_char.last;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor and receiver: compare each transfer against the oldest
  // prediction, then pick the stall for the next cycle.
  // --------------------------------------------------------------------------
  task automatic check_result();
    result_t want;
    if (pending_numbers.size() == 0) begin
      $error("parsed number with none predicted: status %0d, error_code %0d",
             status_o, error_code_o);
      mismatches++;
      return;
    end
    want = pending_numbers.pop_front();
    numbers_checked++;
    if (status_o != want.status) begin
      $error("status: expected %0d, got %0d", want.status, status_o);
      mismatches++;
    end
    if (error_code_o != want.code) begin
      $error("error_code: expected %0d, got %0d", want.code, error_code_o);
      mismatches++;
    end
    if (is_negative_o != want.neg) begin
      $error("is_negative: expected %0d, got %0d", want.neg, is_negative_o);
      mismatches++;
    end
    if (magnitude_o != want.mag) begin
      $error("magnitude: expected %0d, got %0d", want.mag, magnitude_o);
      mismatches++;
    end
    if (fraction_digits_o != want.frac) begin
      $error("fraction_digits: expected %0d, got %0d", want.frac, fraction_digits_o);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left   <= 0;
      hold_done   <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) check_result();
      if (hold_left != 0) begin
        // long hold-off: let the block back up into its input
        hold_left   <= hold_left - 1;
        out_stall_i <= 1'b1;
      end else if (hold_results && !hold_done) begin
        hold_left   <= 300;
        hold_done   <= 1'b1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !calm && ($urandom_range(0, 99) < 33);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic push_char(input logic [7:0] c, input logic last);
    in_item_t it;
    it.chr  = c;
    it.last = last;
    text_q = {text_q, it};
    chars_queued++;
    if (last) fields_queued++;
  endtask

  // Queue a text field; leave it open when closes is low.
  task automatic queue_text(input string t, input logic closes = 1'b1);
    for (int i = 0; i < t.len(); i++) begin
      push_char(t[i], closes && (i == t.len() - 1));
    end
  endtask

  function automatic logic [7:0] blank_char();
    int r;
    r = $urandom_range(0, 5);
    return (r == 5) ? CH_SPACE : CH_TAB + 8'(r);
  endfunction

  function automatic logic [7:0] rand_numeral();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  // Characters that steer the grammar.
  function automatic logic [7:0] odd_char();
    logic [7:0] c;
    case ($urandom_range(0, 9))
      0:       c = CH_PLUS;
      1:       c = CH_MINUS;
      2:       c = CH_POINT;
      3:       c = CH_COMMA;
      4:       c = CH_PCT;
      5:       c = blank_char();
      6:       c = CH_SLASH;
      7:       c = CH_LC_N - CASE_GAP;
      8:       c = CH_LC_A;
      default: c = rand_numeral();
    endcase
    return c;
  endfunction

  // One random field: mostly numbers shaped for the current mode, some
  // unavailable tokens, some noise, and now and then a damaged character.
  task automatic queue_random_field(input logic pct);
    logic [7:0] txt[$];
    int         roll;
    int         n;
    roll = $urandom_range(0, 99);
    if ($urandom_range(0, 3) == 0) txt = {txt, blank_char()};
    if (roll < 12) begin
      case ($urandom_range(0, 5))
        0: txt = {txt, CH_MINUS};
        1: begin
          txt = {txt, CH_LC_N};
          txt = {txt, CH_SLASH};
          txt = {txt, CH_LC_A};
        end
        2: begin
          txt = {txt, CH_LC_N};
          txt = {txt, CH_LC_A};
        end
        3: txt = {txt, CH_LC_N};
        4: begin
          txt = {txt, CH_LC_N};
          txt = {txt, CH_SLASH};
        end
        default: begin
          txt = {txt, CH_LC_N};
          txt = {txt, CH_LC_A};
          txt = {txt, CH_LC_N};
        end
      endcase
      foreach (txt[k]) begin
        if (txt[k] >= CH_LC_A && $urandom_range(0, 1) == 1) txt[k] = txt[k] - CASE_GAP;
      end
    end else if (roll < 30) begin
      repeat ($urandom_range(1, 6)) begin
        txt = {txt, (($urandom_range(0, 1) == 1) ? 8'($urandom_range(0, 255)) : odd_char())};
      end
    end else begin
      case ($urandom_range(0, 2))
        0:       txt = {txt, CH_PLUS};
        1:       txt = {txt, CH_MINUS};
        default: ;
      endcase
      if (!pct && $urandom_range(0, 3) == 0) begin
        // comma groups, sometimes of the wrong size
        n = ($urandom_range(0, 9) == 0) ? 4 : $urandom_range(1, 3);
        repeat (n) txt = {txt, rand_numeral()};
        repeat ($urandom_range(1, 3)) begin
          txt = {txt, CH_COMMA};
          n = ($urandom_range(0, 9) == 0) ? $urandom_range(2, 4) : 3;
          repeat (n) txt = {txt, rand_numeral()};
        end
      end else begin
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(16, 20) : $urandom_range(1, 6);
        repeat (n) txt = {txt, rand_numeral()};
      end
      if ($urandom_range(0, 9) < 4) begin
        txt = {txt, CH_POINT};
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 8) : $urandom_range(0, 4);
        repeat (n) txt = {txt, rand_numeral()};
      end
      if (pct ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 19) == 0)) begin
        txt = {txt, CH_PCT};
      end
      if ($urandom_range(0, 5) == 0) txt[$urandom_range(0, txt.size() - 1)] = odd_char();
    end
    if ($urandom_range(0, 3) == 0) txt = {txt, blank_char()};
    foreach (txt[k]) push_char(txt[k], k == txt.size() - 1);
  endtask

  // Hold off until every queued character is taken and every number is back.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (text_q.size() != 0 || in_valid_i || pending_numbers.size() != 0);
  endtask

  // Write percent_mode while the block is idle.
  task automatic set_mode(input logic m);
    wait_drained();
    // an open field may still be settling inside the block
    repeat (4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= m;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    pct_mode = m;
  endtask

  // --------------------------------------------------------------------------
  // Reset, then the test sequence.
  // --------------------------------------------------------------------------
  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    string zeros;
    int    phase_start;
    zeros = "0.";
    repeat (63) zeros = {zeros, "0"};

    // Decimal mode, as after reset.
    queue_text(" ");                    // blank field
    queue_text("\t-\n");                // lone dash
    queue_text("n/a");
    queue_text("NA");
    queue_text(" +1,234.50 ");          // grouping, scale, trailing blank
    queue_text("-00.0");                // zero carries no sign
    queue_text("+");                    // sign without digits
    queue_text("1.2.3");
    queue_text(".5");                   // no integer part
    queue_text("7.");                   // point with no fraction
    queue_text("1.x");
    queue_text("12,34");                // short last group
    queue_text("1 2");                  // internal blank
    queue_text("1234567890123456789");  // one digit past the bound
    queue_text("999999999999999999");   // largest accepted magnitude
    queue_text(zeros);                  // largest accepted scale
    queue_text({zeros, "0"});           // scale one past the limit
    queue_text("5%");                   // percent sign is an ordinary byte here
    push_char(8'h00, 1'b0);
    push_char(8'hFF, 1'b1);

    // Open a field in decimal mode and close it in percent mode.
    queue_text("8", 1'b0);
    set_mode(1'b1);
    queue_text("%");
    queue_text("12.5%");
    queue_text("12");                   // missing trailing percent
    queue_text("1,000%");               // commas forbidden in percent mode
    queue_text("% ");
    queue_text(" 3 % ");
    queue_text("50%%");

    // Hold a trailing percent, then leave percent mode before the last byte.
    queue_text("7%", 1'b0);
    set_mode(1'b0);
    queue_text(" ");

    // Random phases alternate the mode; one runs without idling, one starts
    // with a long output hold-off.
    for (int phase = 0; phase < 5; phase++) begin
      if (phase != 0) set_mode(phase % 2 == 1);
      calm        = (phase == 2);
      phase_start = chars_queued;
      while (chars_queued - phase_start < 250) queue_random_field(pct_mode);
      if (phase == 3) hold_results = 1'b1;
    end

    wait_drained();
    repeat (8) @(posedge clk_i);

    $display("Checked %0d parsed numbers from %0d characters in %0d fields",
             numbers_checked, chars_queued, fields_queued);
    $display("Both modes, mode changes inside a field, long output back-pressure");
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

### grouped_decimal_text_parser.f
rtl/gdtp_pkg.sv
rtl/gdtp_parse_core.sv
rtl/grouped_decimal_text_parser.sv
rtl/gdtp_checker.sv
tb/tb.sv
